// ===== rtl/pot_pkg.sv =====
// ----------------------------------------------------------------------------
// pot_pkg: shared types and constants of the periodic/one-shot timer bank
// transaction formats, operation and timer state codes, cell control group
// ----------------------------------------------------------------------------
package pot_pkg;

    localparam int NUM_TIMERS_DEF  = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_RESULTS     = 8;
    localparam int EMIT_W          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_INIT    = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_DESTROY = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_UNUSED    = 3'd0,
        ST_CREATED   = 3'd1,
        ST_STARTED   = 3'd2,
        ST_STOPPED   = 3'd3,
        ST_DESTROYED = 3'd4
    } t_tstate;

    typedef enum logic {
        CTL_IDLE,
        CTL_SCAN
    } t_ctl_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  timer_index;
        logic [31:0] start_delay;
        logic [31:0] period;
    } t_cmd_item;

    typedef struct packed {
        logic        fired;
        logic [2:0]  which_timer;
        t_tstate     timer_state;
        logic [31:0] remaining;
        logic        last;
    } t_res_item;

    // broadcast to every cell; the per-cell select qualifies the addressed ops
    typedef struct packed {
        logic do_tick;
        logic do_init;
        logic do_start;
        logic do_stop;
        logic do_destroy;
        logic do_shift;
    } t_cell_ctl;

endpackage

// ===== rtl/periodic_oneshot_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank: bank of periodic and one-shot tick timers
// row of timer cells with a report chain shifting towards cell 0
// ----------------------------------------------------------------------------
// Usage
//   Command channel: i_cmd is taken at a rising edge with start high and busy
//   low. Ops are tick, init, start, stop and destroy.
//   Result channel: o_result is valid for exactly one cycle while o_strobe is
//   high; the receiver cannot hold results off.
//   Init, start, stop and destroy: one result, in the cycle after the
//   transaction, busy stays low, so such a command may follow every cycle.
//   Tick: all timers update in the cycle of the transaction, then busy is
//   high while the report chain shifts one cell per cycle towards cell 0.
//   The scan ends on the last fired timer (or the eighth one reported).
//   Each fired timer gives one result, in index order, the final one marked
//   last; a tick with nothing fired gives none.
//   Unknown ops are dropped without a result.
//   Reset: every timer unused with count zero, no scan pending.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank #(
    parameter int NUM_TIMERS  = pot_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = pot_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pot_pkg::t_cmd_item i_cmd,
    output logic               o_strobe,
    output pot_pkg::t_res_item o_result
);
    import pot_pkg::*;

    t_ctl_state             r_state, n_state;
    logic [EMIT_W-1:0]      r_emit, n_emit;
    logic                   r_strobe, n_strobe;
    t_res_item              r_out, n_out;

    logic                   w_accept;
    t_cell_ctl              w_ctl;
    logic [NUM_TIMERS-1:0]  w_sel;
    logic                   w_in_range;
    logic [NUM_TIMERS-1:0]  w_vld;
    logic [NUM_TIMERS-1:0]  w_any;
    t_res_item              w_slot [NUM_TIMERS];
    t_res_item              w_view [NUM_TIMERS];
    t_res_item              w_view_mux;
    logic                   w_any_behind;
    logic                   w_emit;
    logic                   w_last;
    logic                   w_done;
    logic [63:0]            w_delay_wide;
    logic [63:0]            w_period_wide;

    assign w_accept      = start && !busy;
    assign w_delay_wide  = 64'(i_cmd.start_delay);
    assign w_period_wide = 64'(i_cmd.period);
    assign w_in_range    = (32'(i_cmd.timer_index) < NUM_TIMERS);

    always_comb begin
        w_ctl = '0;
        if (w_accept) begin
            unique case (i_cmd.op)
                OP_TICK:    w_ctl.do_tick    = 1'b1;
                OP_INIT:    w_ctl.do_init    = 1'b1;
                OP_START:   w_ctl.do_start   = 1'b1;
                OP_STOP:    w_ctl.do_stop    = 1'b1;
                OP_DESTROY: w_ctl.do_destroy = 1'b1;
                default:    w_ctl = '0;
            endcase
        end
        w_ctl.do_shift = (r_state == CTL_SCAN);
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
            logic      w_nb_vld;
            t_res_item w_nb_slot;
            logic      w_nb_any;

            assign w_sel[gi] = (32'(i_cmd.timer_index) == gi);

            if (gi == NUM_TIMERS - 1) begin : g_end
                assign w_nb_vld  = 1'b0;
                assign w_nb_slot = '0;
                assign w_nb_any  = 1'b0;
            end else begin : g_mid
                assign w_nb_vld  = w_vld[gi+1];
                assign w_nb_slot = w_slot[gi+1];
                assign w_nb_any  = w_any[gi+1];
            end

            pot_cell #(
                .COUNT_WIDTH (COUNT_WIDTH),
                .CELL_INDEX  (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_sel      (w_sel[gi]),
                .i_delay    (w_delay_wide[COUNT_WIDTH-1:0]),
                .i_period   (w_period_wide[COUNT_WIDTH-1:0]),
                .i_nb_vld   (w_nb_vld),
                .i_nb_slot  (w_nb_slot),
                .i_nb_any   (w_nb_any),
                .o_slot_vld (w_vld[gi]),
                .o_slot     (w_slot[gi]),
                .o_any      (w_any[gi]),
                .o_view     (w_view[gi])
            );
        end

        if (NUM_TIMERS > 1) begin : g_behind
            assign w_any_behind = w_any[1];
        end else begin : g_single
            assign w_any_behind = 1'b0;
        end
    endgenerate

    // read back the addressed timer after the command
    always_comb begin
        w_view_mux = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (w_sel[i]) begin
                w_view_mux = w_view_mux | w_view[i];
            end
        end
        if (!w_in_range) begin
            w_view_mux.fired       = 1'b0;
            w_view_mux.which_timer = i_cmd.timer_index;
            w_view_mux.timer_state = ST_UNUSED;
            w_view_mux.remaining   = '0;
            w_view_mux.last        = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CTL_IDLE: begin
                if (w_ctl.do_tick) begin
                    n_state = CTL_SCAN;
                end
            end
            CTL_SCAN: begin
                if (w_done) begin
                    n_state = CTL_IDLE;
                end
            end
            default: n_state = CTL_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy     = 1'b0;
        w_emit   = 1'b0;
        w_last   = 1'b0;
        w_done   = 1'b0;
        n_emit   = r_emit;
        n_strobe = 1'b0;
        n_out    = r_out;
        unique case (r_state)
            CTL_IDLE: begin
                n_emit = '0;
                if (w_ctl.do_init || w_ctl.do_start || w_ctl.do_stop || w_ctl.do_destroy) begin
                    n_strobe = 1'b1;
                    n_out    = w_view_mux;
                end
            end
            CTL_SCAN: begin
                busy   = 1'b1;
                w_emit = w_vld[0];
                w_last = !w_any_behind || (r_emit == EMIT_W'(MAX_RESULTS - 1));
                // stop once nothing is left behind the head or the cap is hit
                w_done = !w_any_behind || (w_emit && w_last);
                if (w_emit) begin
                    n_strobe      = 1'b1;
                    n_out         = w_slot[0];
                    n_out.last    = w_last;
                    n_emit        = r_emit + EMIT_W'(1);
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CTL_IDLE;
            r_emit   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_emit   <= n_emit;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_tick_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == OP_TICK) |=> busy)
        else $error("tick transaction did not start the report scan");

    a_fired_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.fired) |-> $past(r_state == CTL_SCAN))
        else $error("expiry report outside a scan");

    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.fired) |-> o_result.last)
        else $error("command result not marked last");

    a_emit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= EMIT_W'(MAX_RESULTS))
        else $error("more expiry reports than allowed per tick");

endmodule

// ===== rtl/pot_cell.sv =====
// ----------------------------------------------------------------------------
// pot_cell: one timer of the bank
// holds delay, period, count and state; on a tick loads its report slot,
// which then moves towards cell 0 one place per cycle
// ----------------------------------------------------------------------------
module pot_cell #(
    parameter int COUNT_WIDTH = pot_pkg::COUNT_WIDTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pot_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_sel,
    input  logic [COUNT_WIDTH-1:0] i_delay,
    input  logic [COUNT_WIDTH-1:0] i_period,
    input  logic                   i_nb_vld,
    input  pot_pkg::t_res_item     i_nb_slot,
    input  logic                   i_nb_any,
    output logic                   o_slot_vld,
    output pot_pkg::t_res_item     o_slot,
    output logic                   o_any,
    output pot_pkg::t_res_item     o_view
);
    import pot_pkg::*;

    logic [COUNT_WIDTH-1:0] r_delay, n_delay;
    logic [COUNT_WIDTH-1:0] r_period, n_period;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    t_tstate                r_state, n_state;
    logic                   r_slot_vld;
    t_res_item              r_slot;
    logic [COUNT_WIDTH-1:0] w_dec;
    logic                   w_fire;
    logic [63:0]            w_wide;

    assign w_dec = r_count - COUNT_WIDTH'(1);

    always_comb begin
        n_delay  = r_delay;
        n_period = r_period;
        n_count  = r_count;
        n_state  = r_state;
        w_fire   = 1'b0;
        if (i_ctl.do_tick) begin
            if (r_state == ST_STARTED) begin
                if (r_count == '0) begin
                    w_fire = 1'b1;
                end else begin
                    n_count = w_dec;
                    w_fire  = (w_dec == '0);
                end
                if (w_fire) begin
                    if (r_period != '0) begin
                        n_count = r_period;
                    end else begin
                        n_state = ST_STOPPED;
                    end
                end
            end
        end else if (i_sel) begin
            if (i_ctl.do_init) begin
                n_delay  = i_delay;
                n_period = i_period;
                n_count  = (i_delay != '0) ? i_delay : i_period;
                n_state  = ST_CREATED;
            end else if (i_ctl.do_start) begin
                if (r_state == ST_CREATED || r_state == ST_STOPPED) begin
                    n_count = (r_delay != '0) ? r_delay : r_period;
                    n_state = ST_STARTED;
                end
            end else if (i_ctl.do_stop) begin
                if (r_state == ST_STARTED) begin
                    n_state = ST_STOPPED;
                end
            end else if (i_ctl.do_destroy) begin
                n_state = ST_DESTROYED;
            end
        end
    end

    assign w_wide = 64'(n_count);

    always_comb begin
        o_view.fired       = 1'b0;
        o_view.which_timer = 3'(CELL_INDEX);
        o_view.timer_state = n_state;
        o_view.remaining   = w_wide[31:0];
        o_view.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_state    <= ST_UNUSED;
            r_slot_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            r_state <= n_state;
            if (i_ctl.do_tick) begin
                r_slot_vld <= w_fire;
            end else if (i_ctl.do_shift) begin
                r_slot_vld <= i_nb_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay  <= n_delay;
        r_period <= n_period;
        if (i_ctl.do_tick) begin
            r_slot.fired       <= 1'b1;
            r_slot.which_timer <= 3'(CELL_INDEX);
            r_slot.timer_state <= n_state;
            r_slot.remaining   <= w_wide[31:0];
            r_slot.last        <= 1'b0;
        end else if (i_ctl.do_shift) begin
            r_slot <= i_nb_slot;
        end
    end

    assign o_slot_vld = r_slot_vld;
    assign o_slot     = r_slot;
    // any pending report here or further down the row
    assign o_any      = r_slot_vld | i_nb_any;

endmodule

// ===== test/periodic_oneshot_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_tb: self-checking bench for the timer bank
// a short table of directed commands, then random command sequences; every
// strobed result is checked against an in-bench model of the timer bank
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_tb;

    import pot_pkg::*;

    localparam int NTIM        = NUM_TIMERS_DEF;
    localparam int RAND_ITEMS  = 320;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct {
        t_cmd_item   cmd;
        bit          typed;
        t_tstate     exp_state;
        logic [31:0] exp_remaining;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_cmd_item i_cmd   = '0;
    logic      o_strobe;
    t_res_item o_result;

    logic [31:0] delay_mem  [NTIM];
    logic [31:0] period_mem [NTIM];
    logic [31:0] count_mem  [NTIM];
    t_tstate     state_mem  [NTIM];

    t_res_item pending_results[$];
    t_dir_row  dir_rows[$];
    int        error_count = 0;

    periodic_oneshot_timer_bank dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // expected timer bank behaviour for one accepted command
    task automatic advance_timer_bank(input t_cmd_item c);
        t_res_item   r;
        int          n;
        bit          hit;
        logic [31:0] reload;
        n = 0;
        r = '0;
        if (c.op == OP_TICK) begin
            for (int i = 0; i < NTIM; i++) begin
                if (state_mem[i] == ST_STARTED) begin
                    if (count_mem[i] == 0) begin
                        hit = 1'b1;
                    end else begin
                        count_mem[i] = count_mem[i] - 1;
                        hit = (count_mem[i] == 0);
                    end
                    if (hit) begin
                        if (period_mem[i] != 0) begin
                            count_mem[i] = period_mem[i];
                        end else begin
                            state_mem[i] = ST_STOPPED;
                        end
                        if (n < MAX_RESULTS) begin
                            r.fired       = 1'b1;
                            r.which_timer = i[2:0];
                            r.timer_state = state_mem[i];
                            r.remaining   = count_mem[i];
                            r.last        = 1'b0;
                            pending_results.push_back(r);
                            n++;
                        end
                    end
                end
            end
            if (n > 0) begin
                r = pending_results.pop_back();
                r.last = 1'b1;
                pending_results.push_back(r);
            end
        end else if (c.op <= OP_DESTROY) begin
            case (c.op)
                OP_INIT: begin
                    delay_mem[c.timer_index]  = c.start_delay;
                    period_mem[c.timer_index] = c.period;
                    reload = (c.start_delay != 0) ? c.start_delay : c.period;
                    count_mem[c.timer_index]  = reload;
                    state_mem[c.timer_index]  = ST_CREATED;
                end
                OP_START: begin
                    if (state_mem[c.timer_index] == ST_CREATED ||
                        state_mem[c.timer_index] == ST_STOPPED) begin
                        reload = (delay_mem[c.timer_index] != 0) ?
                                 delay_mem[c.timer_index] : period_mem[c.timer_index];
                        count_mem[c.timer_index] = reload;
                        state_mem[c.timer_index] = ST_STARTED;
                    end
                end
                OP_STOP: begin
                    if (state_mem[c.timer_index] == ST_STARTED) begin
                        state_mem[c.timer_index] = ST_STOPPED;
                    end
                end
                default: begin
                    state_mem[c.timer_index] = ST_DESTROYED;
                end
            endcase
            r.fired       = 1'b0;
            r.which_timer = c.timer_index;
            r.timer_state = state_mem[c.timer_index];
            r.remaining   = count_mem[c.timer_index];
            r.last        = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    // start stays high across back-to-back transactions; one assignment per edge
    task automatic issue_command(input t_cmd_item c, input bit typed,
                                 input t_tstate st, input logic [31:0] rem);
        t_res_item r;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        advance_timer_bank(c);
        if (typed) begin
            r = pending_results.pop_back();
            r.timer_state = st;
            r.remaining   = rem;
            pending_results.push_back(r);
        end
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(99) < 27) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_dir_row dir_row(input logic [2:0] op, input logic [2:0] idx,
                                         input logic [31:0] dly, input logic [31:0] per,
                                         input bit typed, input t_tstate st,
                                         input logic [31:0] rem);
        t_dir_row row;
        row.cmd.op          = op;
        row.cmd.timer_index = idx;
        row.cmd.start_delay = dly;
        row.cmd.period      = per;
        row.typed           = typed;
        row.exp_state       = st;
        row.exp_remaining   = rem;
        return row;
    endfunction

    function automatic logic [31:0] rand_count();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return $urandom;
        end else if (sel == 1) begin
            return 32'hFFFF_FFFF;
        end else if (sel < 4) begin
            return 32'd0;
        end else begin
            return $urandom_range(1, 6);
        end
    endfunction

    // mostly ticks, inits with chosen counts and starts, some stops, destroys and junk ops
    function automatic t_cmd_item rand_command();
        t_cmd_item c;
        int        p;
        p = $urandom_range(99);
        c.timer_index = 3'($urandom_range(NTIM - 1));
        c.start_delay = $urandom;
        c.period      = $urandom;
        if (p < 5) begin
            c.op = 3'($urandom_range(5, 7));
        end else if (p < 45) begin
            c.op = OP_TICK;
        end else if (p < 65) begin
            c.op          = OP_INIT;
            c.start_delay = rand_count();
            c.period      = rand_count();
        end else if (p < 85) begin
            c.op = OP_START;
        end else if (p < 93) begin
            c.op = OP_STOP;
        end else begin
            c.op = OP_DESTROY;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_res_item e;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: timer %0d state %0d remaining %0h",
                       o_result.which_timer, o_result.timer_state, o_result.remaining);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result.fired !== e.fired) begin
                    $error("fired: expected %0d, got %0d", e.fired, o_result.fired);
                    error_count++;
                end
                if (o_result.which_timer !== e.which_timer) begin
                    $error("which_timer: expected %0d, got %0d",
                           e.which_timer, o_result.which_timer);
                    error_count++;
                end
                if (o_result.timer_state !== e.timer_state) begin
                    $error("timer_state: expected %0d, got %0d",
                           e.timer_state, o_result.timer_state);
                    error_count++;
                end
                if (o_result.remaining !== e.remaining) begin
                    $error("remaining: expected %0h, got %0h",
                           e.remaining, o_result.remaining);
                    error_count++;
                end
                if (o_result.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_cmd_item c;
        int        issued;
        int        waited;
        for (int i = 0; i < NTIM; i++) begin
            delay_mem[i]  = '0;
            period_mem[i] = '0;
            count_mem[i]  = '0;
            state_mem[i]  = ST_UNUSED;
        end

        // directed table: op, timer, delay, period, typed expectation
        dir_rows.push_back(dir_row(OP_START,   0, 0, 0, 1, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_STOP,    7, 0, 0, 1, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_DESTROY, 6, 0, 0, 1, ST_DESTROYED, 0));
        dir_rows.push_back(dir_row(OP_TICK,    0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_INIT,    0, 0, 0, 1, ST_CREATED, 0));
        dir_rows.push_back(dir_row(OP_START,   0, 0, 0, 1, ST_STARTED, 0));
        // zero count fires at once and the one-shot stops
        dir_rows.push_back(dir_row(OP_TICK,    0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_INIT, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   1, ST_CREATED, 32'hFFFF_FFFF));
        dir_rows.push_back(dir_row(OP_START,   7, 0, 0, 1, ST_STARTED, 32'hFFFF_FFFF));
        dir_rows.push_back(dir_row(OP_STOP,    7, 0, 0, 1, ST_STOPPED, 32'hFFFF_FFFF));
        dir_rows.push_back(dir_row(OP_STOP,    7, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_START,   7, 0, 0, 0, ST_UNUSED, 0));
        // zero delay falls back to the period
        dir_rows.push_back(dir_row(OP_INIT,    1, 0, 3, 1, ST_CREATED, 3));
        dir_rows.push_back(dir_row(OP_START,   1, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_INIT,    2, 2, 0, 1, ST_CREATED, 2));
        dir_rows.push_back(dir_row(OP_START,   2, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_START,   0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_TICK,    0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_TICK,    0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_TICK,    0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_DESTROY, 1, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_START,   1, 0, 0, 0, ST_UNUSED, 0));
        // init is taken from any state, destroyed too
        dir_rows.push_back(dir_row(OP_INIT,    1, 1, 1, 1, ST_CREATED, 1));
        dir_rows.push_back(dir_row(3'd5,       0, 0, 0, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(3'd7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_UNUSED, 0));
        dir_rows.push_back(dir_row(OP_INIT, 6, 32'hAAAA_AAAA, 32'h5555_5555,
                                   1, ST_CREATED, 32'hAAAA_AAAA));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            maybe_idle(1'b1);
            issue_command(dir_rows[k].cmd, dir_rows[k].typed,
                          dir_rows[k].exp_state, dir_rows[k].exp_remaining);
        end

        issued = 0;
        while (issued < RAND_ITEMS) begin
            c = rand_command();
            // a long run of back-to-back transactions in the middle
            maybe_idle(issued < 120 || issued >= 200);
            issue_command(c, 1'b0, ST_UNUSED, '0);
            if (c.op <= OP_DESTROY) begin
                issued++;
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (NTIM + 4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
